>>> rtl/bffa_pkg.sv
// Shared types and constants of the first-fit extent allocator.
// Depends on nothing; every other file of the block but bffa_ram refers to it by scoped names.
`default_nettype none

package bffa_pkg;

  // Map geometry
  localparam int MapBitsDefault = 4096;
  localparam int WordBits       = 64;
  localparam int WordSelW       = 6;

  // Field and register widths
  localparam int StartW   = 12;
  localparam int LenW     = 13;
  localparam int StatusW  = 2;
  localparam int TotalW   = 13;
  localparam int FdbW     = 12;
  localparam int CfgDataW = 13;
  localparam int CfgIdxW  = 1;

  // Register reset values
  localparam logic [TotalW-1:0] TotalReset = TotalW'(1024);
  localparam logic [FdbW-1:0]   FdbReset   = FdbW'(32);

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_ZERO_LEN = 2'd2,
    ST_RANGE    = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_VOLUME_BLOCKS    = 1'b0,
    CFG_FIRST_DATA_BLOCK = 1'b1
  } cfg_idx_e;

  // Result of evaluating one map word during the search
  typedef struct packed {
    logic                hit;
    logic [WordSelW-1:0] pos;
    logic [LenW-1:0]     carry;
  } fit_res_t;

endpackage

`default_nettype wire

>>> rtl/bffa_intf.sv
// Request and response channel interfaces (valid/ready plus payload).
// Depends on bffa_pkg for the field widths.
`default_nettype none

interface bffa_req_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [bffa_pkg::StartW-1:0]   start_block;
  logic [bffa_pkg::LenW-1:0]     run_length;

  modport source (output valid, command, start_block, run_length, input ready);
  modport sink   (input valid, command, start_block, run_length, output ready);
endinterface

interface bffa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bffa_pkg::StatusW-1:0]  status;
  logic [bffa_pkg::StartW-1:0]   granted_start;

  modport source (output valid, status, granted_start, input ready);
  modport sink   (input valid, status, granted_start, output ready);
endinterface

`default_nettype wire

>>> rtl/bffa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bffa_ram #(
  parameter int Width = 64,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/bffa_fit.sv
// Evaluates one 64-bit map word: finds the lowest bit at which the free run
// reaches the requested length, and the run carried into the next word.
// Depends on bffa_pkg.
`default_nettype none

module bffa_fit (
  input  wire logic [bffa_pkg::WordBits-1:0] used_i,
  input  wire logic [bffa_pkg::LenW-1:0]     carry_i,
  input  wire logic [bffa_pkg::LenW-1:0]     len_i,
  output bffa_pkg::fit_res_t                 res_o
);

  localparam int NW   = bffa_pkg::WordBits;
  localparam int SelW = bffa_pkg::WordSelW;
  localparam int RunW = bffa_pkg::LenW + 1;

  // last-used-bit prefix, log-step
  logic [SelW:0][NW-1:0]           have_s;
  logic [SelW:0][NW-1:0][SelW-1:0] pos_s;
  logic [NW-1:0][RunW-1:0]         run_len;
  logic [NW-1:0]                   hit_vec;

  always_comb begin
    for (int j = 0; j < NW; j++) begin
      have_s[0][j] = used_i[j];
      pos_s[0][j]  = SelW'(j);
    end
    for (int k = 0; k < SelW; k++) begin
      for (int j = 0; j < NW; j++) begin
        if (!have_s[k][j] && (j >= (1 << k))) begin
          have_s[k+1][j] = have_s[k][(j >= (1 << k)) ? j - (1 << k) : j];
          pos_s[k+1][j]  = pos_s[k][(j >= (1 << k)) ? j - (1 << k) : j];
        end else begin
          have_s[k+1][j] = have_s[k][j];
          pos_s[k+1][j]  = pos_s[k][j];
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < NW; j++) begin
      if (have_s[SelW][j]) begin
        run_len[j] = RunW'(j) - RunW'(pos_s[SelW][j]);
      end else begin
        run_len[j] = RunW'(carry_i) + RunW'(j + 1);
      end
      hit_vec[j] = (run_len[j] >= RunW'(len_i));
    end
  end

  always_comb begin
    res_o.hit = |hit_vec;
    res_o.pos = '0;
    for (int j = NW - 1; j >= 0; j--) begin
      if (hit_vec[j]) begin
        res_o.pos = SelW'(j);
      end
    end
    // run length leaving the word; only meaningful when no hit
    res_o.carry = run_len[NW-1][bffa_pkg::LenW-1:0];
  end

endmodule

`default_nettype wire

>>> rtl/bitmap_first_fit_extent_allocator_unit.sv
// Top level of the first-fit extent allocator: control sequencer, config registers,
// result register. Depends on bffa_pkg, bffa_intf, bffa_ram and bffa_fit.
//  - req_i (sink) carries allocate/free commands; rsp_o (source) returns one
//    status/granted_start per command, in order. A transfer happens on a clock edge
//    with valid and ready both high.
//  - cfg_we_i/cfg_idx_i/cfg_data_i write the volume size in blocks (index 0) and
//    first_data_block (index 1); write only while no command is in flight.
//  - The usage map is one bit per block, held as MapBits/64 words of 64 bits in a
//    single RAM. An allocate reads the words from first_data_block upward, one
//    word per cycle through the fit unit, then read-modify-writes the granted run
//    one word per cycle. A free read-modify-writes the words of its run.
//  - Zero length, out-of-range free and early no-room checks go straight to the
//    result; an allocate scans words from first_data_block upward, then marks the
//    run when it finds room; a free marks the words of its run. The word-per-cycle
//    RAM port sets the pace. One command is processed at a time.
//  - Reset clears the control state, then a clearing pass writes every map word to
//    zero with req_i.ready low.
//  - rsp_o is registered: a new command is taken while a result waits; a stalled
//    receiver holds the result and the next finished command waits behind it.
`default_nettype none

module bitmap_first_fit_extent_allocator_unit #(
  parameter int MapBits = bffa_pkg::MapBitsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bffa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bffa_pkg::CfgDataW-1:0] cfg_data_i,
  bffa_req_if.sink                           req_i,
  bffa_rsp_if.source                         rsp_o
);

  localparam int NW       = bffa_pkg::WordBits;
  localparam int SelW     = bffa_pkg::WordSelW;
  localparam int LenW     = bffa_pkg::LenW;
  localparam int StartW   = bffa_pkg::StartW;
  localparam int MapWords = MapBits / NW;
  localparam int AddrW    = (MapWords > 1) ? $clog2(MapWords) : 1;
  // block numbers must hold MapBits and start + length of a free
  localparam int BlkW     = ($clog2(MapBits) + 1 > 14) ? $clog2(MapBits) + 1 : 14;
  localparam int WordW    = BlkW - SelW;
  localparam logic [NW-1:0] Ones = '1;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_MARK  = 5'b01000,
    S_RESP  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [WordW-1:0] ptr_q, ptr_d;     // next word to read
  logic [WordW-1:0] cur_q, cur_d;     // word whose data is on the RAM output
  logic             pend_q, pend_d;   // RAM output holds a live word
  logic [WordW-1:0] ws_q, ws_d;       // first and last word of the search
  logic [WordW-1:0] we_q, we_d;
  logic [NW-1:0]    lo_mask_q, lo_mask_d;
  logic [NW-1:0]    hi_mask_q, hi_mask_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  carry_q, carry_d;
  logic [BlkW-1:0]  lo_q, lo_d;       // run to mark or clear
  logic [BlkW-1:0]  hi_q, hi_d;
  logic             set_q, set_d;
  bffa_pkg::status_e status_q, status_d;
  logic [StartW-1:0] granted_q, granted_d;

  logic [bffa_pkg::TotalW-1:0] total_q;
  logic [bffa_pkg::FdbW-1:0]   fdb_q;

  logic                      out_valid_q;
  bffa_pkg::status_e         out_status_q;
  logic [StartW-1:0]         out_start_q;
  logic                      resp_load;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [NW-1:0]    ram_wdata;
  logic [NW-1:0]    ram_rdata;

  logic [NW-1:0]      scan_used;
  bffa_pkg::fit_res_t fit_res;

  logic [BlkW-1:0] total_ext, fdb_ext, limit, lim_m1, start_ext, len_ext, free_end;
  logic [BlkW-1:0] hit_end, hit_start;
  logic [SelW-1:0] mk_a, mk_b;
  logic [NW-1:0]   mark_mask;

  // ---------------------------------------------------------------- map memory
  bffa_ram #(
    .Width (NW),
    .Depth (MapWords)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ptr_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- fit unit
  // Blocks below first_data_block and at or above the limit count as used.
  assign scan_used = ram_rdata
                   | ((cur_q == ws_q) ? lo_mask_q : '0)
                   | ((cur_q == we_q) ? hi_mask_q : '0);

  bffa_fit u_fit (
    .used_i  (scan_used),
    .carry_i (carry_q),
    .len_i   (len_q),
    .res_o   (fit_res)
  );

  // ---------------------------------------------------------------- address math
  assign total_ext = BlkW'(total_q);
  assign fdb_ext   = BlkW'(fdb_q);
  assign limit     = (total_ext < BlkW'(MapBits)) ? total_ext : BlkW'(MapBits);
  assign lim_m1    = limit - BlkW'(1);
  assign start_ext = BlkW'(req_i.start_block);
  assign len_ext   = BlkW'(req_i.run_length);
  assign free_end  = start_ext + len_ext;

  assign hit_end   = {cur_q, fit_res.pos};
  assign hit_start = hit_end + BlkW'(1) - BlkW'(len_q);

  // Bits of the current word that fall inside [lo, hi]
  assign mk_a      = (cur_q == lo_q[BlkW-1:SelW]) ? lo_q[SelW-1:0] : '0;
  assign mk_b      = (cur_q == hi_q[BlkW-1:SelW]) ? hi_q[SelW-1:0] : '1;
  assign mark_mask = (Ones << mk_a) & (Ones >> (SelW'(NW - 1) - mk_b));

  assign req_i.ready = (state_q == S_IDLE);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    cur_d     = cur_q;
    pend_d    = pend_q;
    ws_d      = ws_q;
    we_d      = we_q;
    lo_mask_d = lo_mask_q;
    hi_mask_d = hi_mask_q;
    len_d     = len_q;
    carry_d   = carry_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    set_d     = set_q;
    status_d  = status_q;
    granted_d = granted_q;
    ram_we    = 1'b0;
    ram_waddr = cur_q[AddrW-1:0];
    ram_wdata = '0;
    resp_load = 1'b0;

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q[AddrW-1:0];
        ptr_d     = ptr_q + WordW'(1);
        if (ptr_q == WordW'(MapWords - 1)) begin
          ptr_d   = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_i.valid) begin
          len_d     = req_i.run_length;
          carry_d   = '0;
          pend_d    = 1'b0;
          granted_d = '0;
          if (req_i.run_length == '0) begin
            status_d = bffa_pkg::ST_ZERO_LEN;
            state_d  = S_RESP;
          end else if (req_i.command == bffa_pkg::CMD_ALLOC) begin
            set_d = 1'b1;
            if (fdb_ext >= limit) begin
              status_d = bffa_pkg::ST_NO_SPACE;
              state_d  = S_RESP;
            end else begin
              ws_d      = fdb_ext[BlkW-1:SelW];
              we_d      = lim_m1[BlkW-1:SelW];
              ptr_d     = fdb_ext[BlkW-1:SelW];
              lo_mask_d = ~(Ones << fdb_ext[SelW-1:0]);
              hi_mask_d = ~(Ones >> (SelW'(NW - 1) - lim_m1[SelW-1:0]));
              state_d   = S_SCAN;
            end
          end else begin
            set_d = 1'b0;
            if (free_end > BlkW'(MapBits)) begin
              status_d = bffa_pkg::ST_RANGE;
              state_d  = S_RESP;
            end else begin
              lo_d     = start_ext;
              hi_d     = free_end - BlkW'(1);
              ptr_d    = start_ext[BlkW-1:SelW];
              status_d = bffa_pkg::ST_OK;
              state_d  = S_MARK;
            end
          end
        end
      end

      S_SCAN: begin
        // read one word ahead while the fit unit looks at the previous one
        if (ptr_q <= we_q) begin
          pend_d = 1'b1;
          cur_d  = ptr_q;
          ptr_d  = ptr_q + WordW'(1);
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          if (fit_res.hit) begin
            lo_d      = hit_start;
            hi_d      = hit_end;
            granted_d = hit_start[StartW-1:0];
            status_d  = bffa_pkg::ST_OK;
            ptr_d     = hit_start[BlkW-1:SelW];
            pend_d    = 1'b0;
            state_d   = S_MARK;
          end else begin
            carry_d = fit_res.carry;
            if (cur_q == we_q) begin
              status_d = bffa_pkg::ST_NO_SPACE;
              state_d  = S_RESP;
            end
          end
        end
      end

      S_MARK: begin
        // read word k+1 while writing back word k
        if (ptr_q <= hi_q[BlkW-1:SelW]) begin
          pend_d = 1'b1;
          cur_d  = ptr_q;
          ptr_d  = ptr_q + WordW'(1);
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = cur_q[AddrW-1:0];
          ram_wdata = set_q ? (ram_rdata | mark_mask) : (ram_rdata & ~mark_mask);
          if (cur_q == hi_q[BlkW-1:SelW]) begin
            state_d = S_RESP;
          end
        end
      end

      S_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          resp_load = 1'b1;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ptr_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      pend_q  <= pend_d;
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    ws_q      <= ws_d;
    we_q      <= we_d;
    lo_mask_q <= lo_mask_d;
    hi_mask_q <= hi_mask_d;
    len_q     <= len_d;
    carry_q   <= carry_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    set_q     <= set_d;
    status_q  <= status_d;
    granted_q <= granted_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= bffa_pkg::TotalReset;
      fdb_q   <= bffa_pkg::FdbReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bffa_pkg::CFG_VOLUME_BLOCKS: begin
          total_q <= cfg_data_i[bffa_pkg::TotalW-1:0];
        end
        bffa_pkg::CFG_FIRST_DATA_BLOCK: begin
          fdb_q <= cfg_data_i[bffa_pkg::FdbW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_load) begin
      out_status_q <= status_q;
      out_start_q  <= granted_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.granted_start = out_start_q;

endmodule

`default_nettype wire

>>> rtl/bffa_checker.sv
// Port-level checks of the allocator, bound to the top level.
// Depends on bffa_pkg and bitmap_first_fit_extent_allocator_unit.
`default_nettype none

module bffa_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         req_valid_i,
  input wire logic                         req_ready_i,
  input wire logic                         rsp_valid_i,
  input wire logic                         rsp_ready_i,
  input wire logic [bffa_pkg::StatusW-1:0] rsp_status_i,
  input wire logic [bffa_pkg::StartW-1:0]  rsp_start_i
);

  logic [1:0] inflight_q;
  logic       req_xfer, rsp_xfer;

  assign req_xfer = req_valid_i && req_ready_i;
  assign rsp_xfer = rsp_valid_i && rsp_ready_i;

  // commands accepted and not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 2'(req_xfer) - 2'(rsp_xfer);
    end
  end

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (inflight_q != 2'd0))
    else $error("response without an outstanding command");

  a_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (rsp_status_i != bffa_pkg::ST_OK)) |-> (rsp_start_i == '0))
    else $error("granted_start nonzero on a failed command");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> (!rsp_valid_i && !req_ready_i))
    else $error("channels active during reset");

  a_clear_pass: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !req_ready_i)
    else $error("command accepted before the map clear finished");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_start_i)))
    else $error("stalled response changed");

endmodule

bind bitmap_first_fit_extent_allocator_unit bffa_checker u_bffa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_start_i  (rsp_o.granted_start)
);

`default_nettype wire

>>> dv/tb_bitmap_first_fit_extent_allocator_unit.sv
// Self-checking testbench for bitmap_first_fit_extent_allocator_unit: directed and random
// allocate/free traffic, checked transfer by transfer against an in-bench usage-map model.
// Depends on bffa_pkg, the bffa_req_if/bffa_rsp_if interfaces and the allocator RTL.
`default_nettype none

// One granted run still held by the stimulus
typedef struct {
  int unsigned base;
  int unsigned len;
} held_run_t;

// Keeps a shadow usage map plus the register copies, predicts the reply of every
// accepted command and holds the replies still owed by the block.
class extent_ledger;
  typedef struct {
    bffa_pkg::status_e                status;
    logic [bffa_pkg::StartW-1:0]      start;
  } reply_t;

  bit          in_use [bffa_pkg::MapBitsDefault];
  int unsigned volume_blocks;
  int unsigned search_floor;
  reply_t      awaited[$];
  held_run_t   live[$];     // granted runs not yet handed back by the stimulus
  int unsigned fail_count;

  function new();
    foreach (in_use[b]) in_use[b] = 1'b0;
    volume_blocks = bffa_pkg::TotalReset;
    search_floor  = bffa_pkg::FdbReset;
    fail_count    = 0;
  endfunction

  function void set_reg(bffa_pkg::cfg_idx_e idx, int unsigned value);
    if (idx == bffa_pkg::CFG_VOLUME_BLOCKS) begin
      volume_blocks = value & 32'h1fff;
    end else begin
      search_floor = value & 32'h0fff;
    end
  endfunction

  // Predicts the reply of one command; an allocate is a first-fit search from the floor up to min(volume, map size)
  function void apply_command(bffa_pkg::cmd_e cmd, int unsigned start, int unsigned len);
    reply_t      r;
    held_run_t   e;
    int unsigned limit;
    int unsigned run;
    int unsigned s;
    r.status = bffa_pkg::ST_NO_SPACE;
    r.start  = '0;
    if (len == 0) begin
      r.status = bffa_pkg::ST_ZERO_LEN;
    end else if (cmd == bffa_pkg::CMD_ALLOC) begin
      limit = (volume_blocks < bffa_pkg::MapBitsDefault) ? volume_blocks
                                                         : bffa_pkg::MapBitsDefault;
      run = 0;
      for (int unsigned b = search_floor; b < limit; b++) begin
        if (in_use[b]) begin
          run = 0;
        end else begin
          run++;
          if (run == len) begin
            s = b + 1 - len;
            for (int unsigned i = s; i <= b; i++) in_use[i] = 1'b1;
            r.status = bffa_pkg::ST_OK;
            r.start  = s[bffa_pkg::StartW-1:0];
            e.base   = s;
            e.len    = len;
            live.push_back(e);
            break;
          end
        end
      end
    end else if (start + len > bffa_pkg::MapBitsDefault) begin
      r.status = bffa_pkg::ST_RANGE;
    end else begin
      for (int unsigned i = start; i < start + len; i++) in_use[i] = 1'b0;
      r.status = bffa_pkg::ST_OK;
    end
    awaited.push_back(r);
  endfunction

  task report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task check_reply(logic [bffa_pkg::StatusW-1:0] status,
                   logic [bffa_pkg::StartW-1:0] granted);
    reply_t want;
    if (awaited.size() == 0) begin
      report($sformatf("result with nothing awaited: status %0d start %0d", status, granted));
      return;
    end
    want = awaited.pop_front();
    if (status !== want.status) begin
      report($sformatf("status %0d, want %0d", status, want.status));
    end
    if (granted !== want.start) begin
      report($sformatf("granted_start %0d, want %0d", granted, want.start));
    end
  endtask
endclass

module tb_bitmap_first_fit_extent_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Long receiver hold-off, and the settle time at the end.
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned SettleCycles = 150;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [bffa_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [bffa_pkg::CfgDataW-1:0] cfg_data;

  bit           hold_replies;   // raised by the stimulus, cleared by the receiver
  int unsigned  burst_left;     // transfers left in the current sender burst
  extent_ledger ledger;

  bffa_req_if req_ch();
  bffa_rsp_if rsp_ch();

  bitmap_first_fit_extent_allocator_unit uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Driving helpers. Everything changes at the falling edge; handshakes are
  // sampled at the rising edge, where a transfer takes place.
  // ---------------------------------------------------------------------------

  // Offer one command and hold it until the block takes it; the prediction is
  // made at the transfer, so the map copy is always in step with the block.
  task automatic send_cmd(bffa_pkg::cmd_e cmd, int unsigned start, int unsigned len);
    @(negedge clk);
    req_ch.valid       = 1'b1;
    req_ch.command     = cmd;
    req_ch.start_block = start[bffa_pkg::StartW-1:0];
    req_ch.run_length  = len[bffa_pkg::LenW-1:0];
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    ledger.apply_command(cmd, start & 32'h0fff, len & 32'h1fff);
  endtask

  // Sender gap: valid low, payload scrambled so idle lanes are not trusted
  task automatic idle_sender(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      req_ch.valid       = 1'b0;
      req_ch.command     = bffa_pkg::cmd_e'($urandom_range(0, 1));
      req_ch.start_block = bffa_pkg::StartW'($urandom);
      req_ch.run_length  = bffa_pkg::LenW'($urandom);
    end
  endtask

  // Stop offering and wait until every owed reply has been transferred
  task automatic drain_results();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (ledger.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(bffa_pkg::cfg_idx_e idx, int unsigned value);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = value[bffa_pkg::CfgDataW-1:0];
    @(negedge clk);
    cfg_we   = 1'b0;
    cfg_data = bffa_pkg::CfgDataW'($urandom);
    ledger.set_reg(idx, value);
  endtask

  // Registers change only with the block idle
  task automatic set_volume(int unsigned total, int unsigned lowest);
    drain_results();
    write_reg(bffa_pkg::CFG_VOLUME_BLOCKS, total);
    write_reg(bffa_pkg::CFG_FIRST_DATA_BLOCK, lowest);
  endtask

  // Mostly allocate/free pairs of real extents, with stray frees, zero lengths
  // and out-of-range frees as noise. max_len keeps most runs short so the map
  // churns instead of filling; a few very long runs still get through.
  task automatic random_traffic(int unsigned count, int unsigned max_len);
    int unsigned    pick;
    int unsigned    idx;
    int unsigned    start;
    int unsigned    len;
    bffa_pkg::cmd_e cmd;
    held_run_t      ext;
    repeat (count) begin
      if (burst_left == 0) begin
        idle_sender($urandom_range(1, 15));
        burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
      end
      burst_left--;
      pick  = $urandom_range(0, 99);
      start = $urandom_range(0, 4095);
      if (pick < 50) begin
        cmd  = bffa_pkg::CMD_ALLOC;
        pick = $urandom_range(0, 99);
        if (pick < 3)       len = 0;
        else if (pick < 80) len = $urandom_range(1, max_len);
        else if (pick < 96) len = $urandom_range(1, 4 * max_len);
        else                len = $urandom_range(1, 4096);
      end else if (pick < 85 && ledger.live.size() != 0) begin
        // hand back a granted run
        cmd = bffa_pkg::CMD_FREE;
        idx = $urandom_range(0, ledger.live.size() - 1);
        ext = ledger.live[idx];
        ledger.live.delete(idx);
        start = ext.base;
        len   = ext.len;
      end else if (pick < 95) begin
        cmd = bffa_pkg::CMD_FREE;
        len = $urandom_range(0, 64);
      end else begin
        // run that passes the end of the map
        cmd   = bffa_pkg::CMD_FREE;
        start = $urandom_range(3584, 4095);
        len   = $urandom_range(4097 - start, 4096);
      end
      send_cmd(cmd, start, len);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: switches between stall patterns of random length; on request it
  // holds ready low for a long stretch so the block backs up into its input.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned span;
    int unsigned pct;
    rsp_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_replies) begin
        repeat (HoldCycles) begin
          @(negedge clk);
          rsp_ch.ready = 1'b0;
        end
        hold_replies = 1'b0;
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            pct = 100;
          end
          1: begin
            pct = 70;
          end
          2: begin
            pct = 40;
          end
          default: begin
            pct = 15;
          end
        endcase
        span = $urandom_range(10, 150);
        repeat (span) begin
          @(negedge clk);
          rsp_ch.ready = ($urandom_range(1, 100) <= pct);
        end
      end
    end
  end

  // Reply transfers are checked at the edge that completes them
  always @(posedge clk) begin
    if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      ledger.check_reply(rsp_ch.status, rsp_ch.granted_start);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    ledger             = new();
    hold_replies       = 1'b0;
    burst_left         = 0;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = bffa_pkg::CFG_VOLUME_BLOCKS;
    cfg_data           = '0;
    req_ch.valid       = 1'b0;
    req_ch.command     = bffa_pkg::CMD_ALLOC;
    req_ch.start_block = '0;
    req_ch.run_length  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // the clearing pass after reset shows up as ready low; send_cmd waits on it

    // Directed, at the reset settings (1024 blocks, data from block 32)
    send_cmd(bffa_pkg::CMD_ALLOC, 0, 0);          // zero length, both commands
    send_cmd(bffa_pkg::CMD_FREE, 4095, 0);
    send_cmd(bffa_pkg::CMD_ALLOC, 4095, 1);       // start field ignored on allocate
    send_cmd(bffa_pkg::CMD_ALLOC, 0, 64);
    send_cmd(bffa_pkg::CMD_ALLOC, 0, 4096);       // longer than the volume
    send_cmd(bffa_pkg::CMD_ALLOC, 0, 927);        // fills up to the last block exactly
    send_cmd(bffa_pkg::CMD_ALLOC, 0, 1);          // volume full
    send_cmd(bffa_pkg::CMD_FREE, 40, 8);
    send_cmd(bffa_pkg::CMD_ALLOC, 0, 9);          // hole one block too short
    send_cmd(bffa_pkg::CMD_ALLOC, 0, 8);          // drops into the hole
    send_cmd(bffa_pkg::CMD_FREE, 0, 4096);        // whole map, ends right at the map end
    send_cmd(bffa_pkg::CMD_FREE, 4095, 1);
    send_cmd(bffa_pkg::CMD_FREE, 4095, 2);        // one past the map end
    send_cmd(bffa_pkg::CMD_FREE, 1, 4096);
    send_cmd(bffa_pkg::CMD_FREE, 0, 32);          // below first data block, already free
    send_cmd(bffa_pkg::CMD_ALLOC, 0, 992);        // whole data area
    send_cmd(bffa_pkg::CMD_FREE, 12'haaa, 13'h0aaa);
    send_cmd(bffa_pkg::CMD_FREE, 12'h555, 13'h1000);
    send_cmd(bffa_pkg::CMD_FREE, 0, 1024);
    send_cmd(bffa_pkg::CMD_ALLOC, 12'haaa, 13'h0555);
    send_cmd(bffa_pkg::CMD_ALLOC, 12'h555, 100);

    // Largest volume, search from block 0; pause mid-way until all replies are in
    set_volume(4096, 0);
    random_traffic(150, 48);
    drain_results();
    random_traffic(200, 64);

    // Volume larger than the map, search from the last block only
    set_volume(8191, 4095);
    random_traffic(40, 2);

    // Single-block volume
    set_volume(1, 0);
    random_traffic(40, 2);

    // Empty volume: every allocate of nonzero length finds no room
    set_volume(0, 32);
    random_traffic(30, 16);

    // Search start beyond the volume end
    set_volume(100, 200);
    random_traffic(20, 16);

    // Random geometry, with a long receiver hold-off while commands keep coming
    begin
      int unsigned total;
      total = $urandom_range(64, 4096);
      set_volume(total, $urandom_range(0, total - 1));
    end
    hold_replies = 1'b1;
    random_traffic(350, 40);

    // Upper data bit set on the first-data-block write; only 12 bits are kept
    set_volume(1024, 32'h1000 | 40);
    random_traffic(300, 32);

    begin
      int unsigned total;
      total = $urandom_range(1, 4096);
      set_volume(total, $urandom_range(0, 4095));
    end
    random_traffic(150, 24);
    set_volume(3000, 0);
    random_traffic(150, 96);

    drain_results();
    repeat (SettleCycles) @(posedge clk);
    if (ledger.fail_count == 0 && ledger.awaited.size() == 0) begin
      $display("tb_bitmap_first_fit_extent_allocator_unit: PASS");
    end else begin
      $display("tb_bitmap_first_fit_extent_allocator_unit: FAIL");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin
    #10_000_000;
    $display("tb_bitmap_first_fit_extent_allocator_unit: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
